// ----- src/dscmp_pkg.sv -----
`default_nettype none

package dscmp_pkg;

    localparam int SIDES = 6;
    localparam int IDX_W = (SIDES > 2) ? $clog2(SIDES) : 1;

    // four matrix slots, each laid out as {row, column}
    localparam int SLOT_W = 2;
    localparam int ADDR_W = SLOT_W + 2 * IDX_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;

    localparam int TOTAL_W = 60;
    localparam int COUNT_W = 30;

    typedef logic [COUNT_W-1:0] elem_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [SLOT_W-1:0] slot_t;

    localparam elem_t MODULUS = 30'd1000000007;
    // barrett factor floor(2^60 / p), fits in 31 bits
    localparam logic [30:0] MU = 31'(64'h1000_0000_0000_0000 / 64'd1000000007);
    localparam logic [31:0] MOD32 = {2'b00, MODULUS};
    localparam logic [31:0] TWO_MOD32 = {1'b0, MODULUS, 1'b0};

    localparam idx_t IDX_MAX = IDX_W'(SIDES - 1);

    // f(0) = 1, f(k) = 2^(k-1) for 0 < k < SIDES
    function automatic elem_t seed_value(input idx_t k);
        elem_t v;
        if (k == '0)
        begin
            v = elem_t'(1);
        end
        else
        begin
            v = elem_t'(1) << (k - idx_t'(1));
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- src/dice_sum_count_matrix_power_unit.sv -----
`default_nettype none

// channel   | ports                          | beat
// ----------+--------------------------------+-----------------------------
// command   | start, busy, target_total[59:0] | start high while busy low
// result    | done, way_count[29:0]          | done high for one cycle
//
// totals below SIDES are answered in the cycle after the command, busy stays low
// larger totals: the identity and companion matrix are loaded, then each matrix
// product runs on the one modular mac pipe, with a pick step after the load, after
// each squaring and after the last product, and the dot product comes last; one
// product per set bit of total-(SIDES-1) and one squaring per bit below its top bit
// async active-low reset returns the sequencer to idle; the matrix memory
// is not cleared. done cannot be held off, busy drops with the done beat

module dice_sum_count_matrix_power_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [dscmp_pkg::TOTAL_W-1:0]   target_total,
    output logic                                  done,
    output logic      [dscmp_pkg::COUNT_W-1:0]   way_count
);

    import dscmp_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_INIT      = 7'b0000010,
        ST_PICK      = 7'b0000100,
        ST_RUN       = 7'b0001000,
        ST_DRAIN     = 7'b0010000,
        ST_DOT       = 7'b0100000,
        ST_DOT_DRAIN = 7'b1000000
    } state_t;

    typedef struct packed {
        logic v;
        logic first;
        logic wr;
        logic fin;
        logic dot;
        idx_t row;
        idx_t col;
    } tag_t;

    localparam int PIPE_N = 5;

    function automatic slot_t free_slot_of(input slot_t a, input slot_t b);
        slot_t s;
        priority if (a != slot_t'(0) && b != slot_t'(0))
        begin
            s = slot_t'(0);
        end
        else if (a != slot_t'(1) && b != slot_t'(1))
        begin
            s = slot_t'(1);
        end
        else
        begin
            s = slot_t'(2);
        end
        return s;
    endfunction

    state_t state_reg, state_next;
    logic [TOTAL_W-1:0] power_reg, power_next;
    slot_t res_ptr_reg, res_ptr_next;
    slot_t base_ptr_reg, base_ptr_next;
    logic op_sq_reg, op_sq_next;
    logic init_sel_reg, init_sel_next;
    idx_t cnt_i_reg, cnt_i_next;
    idx_t cnt_j_reg, cnt_j_next;
    idx_t cnt_m_reg, cnt_m_next;
    logic done_reg, done_next;
    elem_t way_count_reg, way_count_next;

    tag_t tag_reg [1:PIPE_N];
    tag_t tag0;

    elem_t seed_reg;
    logic [59:0] prod_reg;
    logic [61:0] q2_reg;
    logic [31:0] plo_reg;
    logic [31:0] r_reg;
    elem_t red_reg;
    elem_t acc_reg;

    slot_t free_slot;
    logic [ADDR_W-1:0] rd_addr_a, rd_addr_b, wr_addr;
    elem_t rd_data_a, rd_data_b, wr_data;
    logic wr_en, pipe_we, init_we;
    elem_t init_data;
    elem_t op_b;
    logic [31:0] qp_lo, r_val;
    elem_t red_val;
    logic [30:0] acc_sum;
    elem_t acc_next;

    assign free_slot = free_slot_of(res_ptr_reg, base_ptr_reg);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        power_next     = power_reg;
        res_ptr_next   = res_ptr_reg;
        base_ptr_next  = base_ptr_reg;
        op_sq_next     = op_sq_reg;
        init_sel_next  = init_sel_reg;
        cnt_i_next     = cnt_i_reg;
        cnt_j_next     = cnt_j_reg;
        cnt_m_next     = cnt_m_reg;
        done_next      = 1'b0;
        way_count_next = way_count_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (target_total < TOTAL_W'(SIDES))
                    begin
                        way_count_next = seed_value(target_total[IDX_W-1:0]);
                        done_next      = 1'b1;
                    end
                    else
                    begin
                        power_next    = target_total - TOTAL_W'(SIDES - 1);
                        res_ptr_next  = slot_t'(0);
                        base_ptr_next = slot_t'(1);
                        init_sel_next = 1'b0;
                        cnt_i_next    = '0;
                        cnt_j_next    = '0;
                        cnt_m_next    = '0;
                        state_next    = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                if (cnt_j_reg == IDX_MAX)
                begin
                    cnt_j_next = '0;
                    if (cnt_i_reg == IDX_MAX)
                    begin
                        cnt_i_next    = '0;
                        init_sel_next = 1'b1;
                        if (init_sel_reg)
                        begin
                            state_next = ST_PICK;
                        end
                    end
                    else
                    begin
                        cnt_i_next = cnt_i_reg + idx_t'(1);
                    end
                end
                else
                begin
                    cnt_j_next = cnt_j_reg + idx_t'(1);
                end
            end
            ST_PICK:
            begin
                cnt_i_next = '0;
                cnt_j_next = '0;
                cnt_m_next = '0;
                if (power_reg == '0)
                begin
                    state_next = ST_DOT;
                end
                else
                begin
                    op_sq_next = ~power_reg[0];
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cnt_m_reg == IDX_MAX)
                begin
                    cnt_m_next = '0;
                    if (cnt_j_reg == IDX_MAX)
                    begin
                        cnt_j_next = '0;
                        if (cnt_i_reg == IDX_MAX)
                        begin
                            cnt_i_next = '0;
                            state_next = ST_DRAIN;
                        end
                        else
                        begin
                            cnt_i_next = cnt_i_reg + idx_t'(1);
                        end
                    end
                    else
                    begin
                        cnt_j_next = cnt_j_reg + idx_t'(1);
                    end
                end
                else
                begin
                    cnt_m_next = cnt_m_reg + idx_t'(1);
                end
            end
            ST_DRAIN:
            begin
                // last element of the product lands in the free slot
                if (tag_reg[PIPE_N].v && tag_reg[PIPE_N].fin)
                begin
                    if (op_sq_reg)
                    begin
                        base_ptr_next = free_slot;
                        power_next    = power_reg >> 1;
                        state_next    = ST_PICK;
                    end
                    else
                    begin
                        res_ptr_next = free_slot;
                        if (power_reg[TOTAL_W-1:1] == '0)
                        begin
                            power_next = '0;
                            state_next = ST_PICK;
                        end
                        else
                        begin
                            op_sq_next = 1'b1;
                            state_next = ST_RUN;
                        end
                    end
                end
            end
            ST_DOT:
            begin
                if (cnt_j_reg == IDX_MAX)
                begin
                    cnt_j_next = '0;
                    state_next = ST_DOT_DRAIN;
                end
                else
                begin
                    cnt_j_next = cnt_j_reg + idx_t'(1);
                end
            end
            ST_DOT_DRAIN:
            begin
                if (tag_reg[PIPE_N].v && tag_reg[PIPE_N].fin)
                begin
                    way_count_next = acc_next;
                    done_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // issue side: read addresses and tag for the beat entering the mac pipe
    always_comb
    begin
        tag0       = '0;
        tag0.row   = cnt_i_reg;
        tag0.col   = cnt_j_reg;
        rd_addr_a  = {op_sq_reg ? base_ptr_reg : res_ptr_reg, cnt_i_reg, cnt_m_reg};
        rd_addr_b  = {base_ptr_reg, cnt_m_reg, cnt_j_reg};
        if (state_reg == ST_RUN)
        begin
            tag0.v     = 1'b1;
            tag0.first = (cnt_m_reg == '0);
            tag0.wr    = (cnt_m_reg == IDX_MAX);
            tag0.fin   = (cnt_m_reg == IDX_MAX) && (cnt_j_reg == IDX_MAX)
                         && (cnt_i_reg == IDX_MAX);
        end
        else if (state_reg == ST_DOT)
        begin
            // top row of the result against the reversed seeds
            rd_addr_a  = {res_ptr_reg, idx_t'(0), cnt_j_reg};
            tag0.v     = 1'b1;
            tag0.first = (cnt_j_reg == '0);
            tag0.wr    = (cnt_j_reg == IDX_MAX);
            tag0.fin   = (cnt_j_reg == IDX_MAX);
            tag0.dot   = 1'b1;
        end
    end

    // matrix load: slot 0 identity, slot 1 companion matrix
    always_comb
    begin
        init_we   = (state_reg == ST_INIT);
        init_data = '0;
        if (init_sel_reg)
        begin
            init_data[0] = (cnt_i_reg == '0) || (cnt_i_reg == cnt_j_reg + idx_t'(1));
        end
        else
        begin
            init_data[0] = (cnt_i_reg == cnt_j_reg);
        end
    end

    // modular mac datapath
    assign op_b  = tag_reg[1].dot ? seed_reg : rd_data_b;
    assign qp_lo = 32'({1'b0, q2_reg[61:31]} * MOD32);
    assign r_val = plo_reg - qp_lo;

    always_comb
    begin
        // barrett remainder is below three times the modulus
        priority if (r_reg >= TWO_MOD32)
        begin
            red_val = elem_t'(r_reg - TWO_MOD32);
        end
        else if (r_reg >= MOD32)
        begin
            red_val = elem_t'(r_reg - MOD32);
        end
        else
        begin
            red_val = elem_t'(r_reg);
        end
    end

    always_comb
    begin
        acc_sum = {1'b0, acc_reg} + {1'b0, red_reg};
        if (tag_reg[PIPE_N].first)
        begin
            acc_next = red_reg;
        end
        else if (acc_sum >= {1'b0, MODULUS})
        begin
            acc_next = elem_t'(acc_sum - {1'b0, MODULUS});
        end
        else
        begin
            acc_next = acc_sum[COUNT_W-1:0];
        end
    end

    assign pipe_we = tag_reg[PIPE_N].v && tag_reg[PIPE_N].wr && !tag_reg[PIPE_N].dot;
    assign wr_en   = init_we || pipe_we;
    assign wr_addr = init_we ? {init_sel_reg ? slot_t'(1) : slot_t'(0), cnt_i_reg, cnt_j_reg}
                             : {free_slot, tag_reg[PIPE_N].row, tag_reg[PIPE_N].col};
    assign wr_data = init_we ? init_data : acc_next;

    dscmp_ram #(
        .WIDTH(COUNT_W),
        .DEPTH(RAM_DEPTH)
    ) u_mat_ram (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr_a(rd_addr_a),
        .rd_data_a(rd_data_a),
        .rd_addr_b(rd_addr_b),
        .rd_data_b(rd_data_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            power_reg     <= '0;
            res_ptr_reg   <= slot_t'(0);
            base_ptr_reg  <= slot_t'(1);
            op_sq_reg     <= 1'b0;
            init_sel_reg  <= 1'b0;
            cnt_i_reg     <= '0;
            cnt_j_reg     <= '0;
            cnt_m_reg     <= '0;
            done_reg      <= 1'b0;
            for (int k = 1; k <= PIPE_N; k++)
            begin
                tag_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            power_reg     <= power_next;
            res_ptr_reg   <= res_ptr_next;
            base_ptr_reg  <= base_ptr_next;
            op_sq_reg     <= op_sq_next;
            init_sel_reg  <= init_sel_next;
            cnt_i_reg     <= cnt_i_next;
            cnt_j_reg     <= cnt_j_next;
            cnt_m_reg     <= cnt_m_next;
            done_reg      <= done_next;
            tag_reg[1]    <= tag0;
            for (int k = 2; k <= PIPE_N; k++)
            begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        way_count_reg <= way_count_next;
        seed_reg      <= seed_value(IDX_MAX - cnt_j_reg);
        prod_reg      <= {30'b0, rd_data_a} * {30'b0, op_b};
        q2_reg        <= {31'b0, prod_reg[59:29]} * {31'b0, MU};
        plo_reg       <= prod_reg[31:0];
        r_reg         <= r_val;
        red_reg       <= red_val;
        if (tag_reg[PIPE_N].v)
        begin
            acc_reg <= acc_next;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign way_count = way_count_reg;

`ifndef SYNTHESIS
    a_dest_free: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_we |-> (free_slot != res_ptr_reg) && (free_slot != base_ptr_reg))
        else $error("product written over a source matrix");

    a_small_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && target_total < TOTAL_W'(SIDES)) |=> done)
        else $error("small total not answered in one cycle");

    a_done_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (way_count < MODULUS))
        else $error("result not reduced");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
        else $error("result beat without a command");
`endif

endmodule

`default_nettype wire

// ----- src/dscmp_ram.sv -----
`default_nettype none

module dscmp_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic      [WIDTH-1:0]         rd_data_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dscmp_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 10;
    localparam int DIR_ROWS = 18;
    localparam int RAND_ITEMS = 100;
    localparam int IDLE_PCT = 11;
    localparam int CALM_LO = DIR_ROWS + 30;
    localparam int CALM_HI = DIR_ROWS + 60;
    localparam int PAUSE_A = DIR_ROWS;
    localparam int PAUSE_B = DIR_ROWS + 70;
    localparam int STALL_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 64;
    localparam int MAX_REPORTS = 10;

    typedef logic [TOTAL_W-1:0] total_t;
    typedef logic [SIDES*SIDES-1:0][COUNT_W-1:0] mat_t;

    typedef struct packed {
        total_t total;
        logic   pinned;
        elem_t  count;
    } dir_row_t;

    typedef struct packed {
        total_t total;
        elem_t  count;
    } way_beat_t;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   start;
    logic   busy;
    total_t target_total;
    logic   done;
    elem_t  way_count;

    total_t    stim_total[$];
    logic      stim_pinned[$];
    elem_t     stim_count[$];
    way_beat_t pending_counts[$];

    int next_item = 0;
    int stall_cycles = 0;
    int mismatches = 0;
    bit timed_out = 1'b0;

    dice_sum_count_matrix_power_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .target_total (target_total),
        .done         (done),
        .way_count    (way_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic elem_t mod_sum(input elem_t a, input elem_t b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, MODULUS})
        begin
            s = s - {1'b0, MODULUS};
        end
        return s[COUNT_W-1:0];
    endfunction

    function automatic elem_t mod_product(input elem_t a, input elem_t b);
        longint unsigned p;
        p = 64'(a) * 64'(b);
        return elem_t'(p % 64'(MODULUS));
    endfunction

    function automatic mat_t mat_product(input mat_t x, input mat_t y);
        mat_t  r;
        elem_t acc;
        for (int i = 0; i < SIDES; i++)
        begin
            for (int j = 0; j < SIDES; j++)
            begin
                acc = '0;
                for (int m = 0; m < SIDES; m++)
                begin
                    acc = mod_sum(acc, mod_product(x[i*SIDES+m], y[m*SIDES+j]));
                end
                r[i*SIDES+j] = acc;
            end
        end
        return r;
    endfunction

    // ways to throw exactly total with faces 1..SIDES, mod p
    function automatic elem_t predict_way_count(input total_t total);
        mat_t   base;
        mat_t   power_acc;
        total_t exponent;
        elem_t  seed [SIDES];
        elem_t  ways;
        for (int k = 0; k < SIDES; k++)
        begin
            seed[k] = (k == 0) ? elem_t'(1) : elem_t'(1) << (k - 1);
        end
        if (total < total_t'(SIDES))
        begin
            ways = seed[int'(total)];
        end
        else
        begin
            base = '0;
            power_acc = '0;
            for (int i = 0; i < SIDES; i++)
            begin
                base[i] = elem_t'(1);
                power_acc[i*SIDES+i] = elem_t'(1);
            end
            for (int i = 1; i < SIDES; i++)
            begin
                base[i*SIDES+i-1] = elem_t'(1);
            end
            exponent = total - total_t'(SIDES - 1);
            while (exponent != '0)
            begin
                if (exponent[0])
                begin
                    power_acc = mat_product(power_acc, base);
                end
                base = mat_product(base, base);
                exponent = exponent >> 1;
            end
            ways = '0;
            for (int j = 0; j < SIDES; j++)
            begin
                ways = mod_sum(ways, mod_product(seed[SIDES-1-j], power_acc[j]));
            end
        end
        return ways;
    endfunction

    task automatic note_mismatch(input string what, input total_t total,
                                 input elem_t want, input elem_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("%s: total %0d expected %0d got %0d", what, total, want, got);
        end
    endtask

    // one clock: check a result beat, log a command beat, drive the next one
    task automatic run_cycle(input bit may_send);
        way_beat_t head;
        bit        progress;
        bit        send;
        @(posedge clk);
        progress = 1'b0;
        if (done)
        begin
            progress = 1'b1;
            if (pending_counts.size() == 0)
            begin
                note_mismatch("result with nothing pending", '0, '0, way_count);
            end
            else
            begin
                head = pending_counts.pop_front();
                if (way_count !== head.count)
                begin
                    note_mismatch("way_count mismatch", head.total, head.count, way_count);
                end
            end
        end
        if (start && !busy)
        begin
            progress = 1'b1;
            head.total = stim_total[next_item];
            head.count = stim_pinned[next_item] ? stim_count[next_item]
                                                : predict_way_count(head.total);
            pending_counts.push_back(head);
            next_item++;
        end
        stall_cycles = progress ? 0 : stall_cycles + 1;

        send = may_send && (next_item < stim_total.size());
        // hold off until the block has answered everything
        if (send && (next_item == PAUSE_A || next_item == PAUSE_B) &&
            pending_counts.size() != 0)
        begin
            send = 1'b0;
        end
        if (send && !(next_item >= CALM_LO && next_item < CALM_HI) &&
            $urandom_range(0, 99) < IDLE_PCT)
        begin
            send = 1'b0;
        end
        start <= send;
        if (send)
        begin
            target_total <= stim_total[next_item];
        end
    endtask

    initial
    begin
        dir_row_t dir_table [DIR_ROWS];
        total_t   t;
        int       pick;
        int       bits;

        start = 1'b0;
        target_total = '0;
        rst_n = 1'b0;

        // small totals come from the seeds, the rest need the matrix power
        dir_table = '{
            '{60'd0,                1'b1, 30'd1},
            '{60'd1,                1'b1, 30'd1},
            '{60'd2,                1'b1, 30'd2},
            '{60'd3,                1'b1, 30'd4},
            '{60'd4,                1'b1, 30'd8},
            '{60'd5,                1'b1, 30'd16},
            '{60'd6,                1'b1, 30'd32},
            '{60'd7,                1'b1, 30'd63},
            '{60'd8,                1'b0, 30'd0},
            '{60'd9,                1'b0, 30'd0},
            '{60'd11,               1'b0, 30'd0},
            '{60'd13,               1'b0, 30'd0},
            '{60'd64,               1'b0, 30'd0},
            '{60'd1000000007,       1'b0, 30'd0},
            '{60'h0_0001_0000_0005, 1'b0, 30'd0},
            '{60'h555555555555555,  1'b0, 30'd0},
            '{60'haaaaaaaaaaaaaaa,  1'b0, 30'd0},
            '{60'hfffffffffffffff,  1'b0, 30'd0}
        };
        for (int n = 0; n < DIR_ROWS; n++)
        begin
            stim_total.push_back(dir_table[n].total);
            stim_pinned.push_back(dir_table[n].pinned);
            stim_count.push_back(dir_table[n].count);
        end

        // mostly short totals, a few wide ones since run time grows with width
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
            begin
                t = total_t'($urandom_range(0, SIDES + 2));
            end
            else if (pick < 85)
            begin
                bits = $urandom_range(4, 14);
                t = total_t'($urandom_range(0, (32'd1 << bits) - 32'd1));
            end
            else if (pick < 95)
            begin
                bits = $urandom_range(15, 40);
                t = total_t'({$urandom, $urandom}) & ((total_t'(1) << bits) - total_t'(1));
            end
            else
            begin
                t = total_t'({$urandom, $urandom});
            end
            stim_total.push_back(t);
            stim_pinned.push_back(1'b0);
            stim_count.push_back('0);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (!timed_out && (next_item < stim_total.size() || pending_counts.size() != 0))
        begin
            run_cycle(1'b1);
            timed_out = (stall_cycles >= STALL_LIMIT);
        end
        for (int n = 0; n < DRAIN_CYCLES && !timed_out; n++)
        begin
            run_cycle(1'b0);
        end

        if (pending_counts.size() != 0)
        begin
            $display("%0d expected results never arrived", pending_counts.size());
            mismatches += pending_counts.size();
        end
        if (!timed_out && mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
